>>> sv/rhc_pkg.sv
package rhc_pkg;

    // pixel channel and result field widths
    localparam int RHC_CHAN_W = 8;
    localparam int RHC_HUE_W  = 16;
    localparam int RHC_SAT_W  = 16;

    // quotient bits produced by each divider
    localparam int RHC_QUO_W  = 16;

    // six times the largest delta (6 * 255 = 1530) fits in 11 bits
    localparam int RHC_SPAN_W = 11;

    // quotient bits resolved per divider stage (must divide RHC_QUO_W)
    localparam int RHC_DIV_STEP = 2;

    // packed stream widths
    localparam int RHC_IN_W  = 3 * RHC_CHAN_W;
    localparam int RHC_OUT_W = RHC_HUE_W + RHC_SAT_W + RHC_CHAN_W;

endpackage

>>> sv/rhc_div.sv
module rhc_div #(
    parameter int REM_W  = 8,
    parameter int STEP_N = rhc_pkg::RHC_DIV_STEP
) (
    input  logic                                  i_clk,
    input  logic [rhc_pkg::RHC_QUO_W/STEP_N-1:0]  i_en,     // per stage load enable
    input  logic [REM_W-1:0]                      i_rem,    // upper dividend bits, below divisor
    input  logic [rhc_pkg::RHC_QUO_W-1:0]         i_work,   // lower dividend bits
    input  logic [REM_W-1:0]                      i_dvs,    // divisor, nonzero
    output logic [rhc_pkg::RHC_QUO_W-1:0]         o_quo
);
    import rhc_pkg::*;

    localparam int NST = RHC_QUO_W / STEP_N;

    logic [REM_W-1:0]     r_rem  [NST];
    logic [RHC_QUO_W-1:0] r_work [NST];
    logic [REM_W-1:0]     r_dvs  [NST];

    logic [REM_W-1:0]     a_rem  [NST];
    logic [RHC_QUO_W-1:0] a_work [NST];
    logic [REM_W-1:0]     a_dvs  [NST];

    logic [REM_W-1:0]     n_rem  [NST];
    logic [RHC_QUO_W-1:0] n_work [NST];

    // stage operands: ports feed the first stage, each register the next
    always_comb begin
        a_rem[0]  = i_rem;
        a_work[0] = i_work;
        a_dvs[0]  = i_dvs;
        for (int k = 1; k < NST; k++) begin
            a_rem[k]  = r_rem[k-1];
            a_work[k] = r_work[k-1];
            a_dvs[k]  = r_dvs[k-1];
        end
    end

    // restoring division, STEP_N quotient bits per stage
    // work shifts dividend bits out the top and quotient bits in at the bottom
    always_comb begin
        logic [REM_W-1:0]     rem;
        logic [RHC_QUO_W-1:0] work;
        logic [REM_W:0]       trial;
        for (int k = 0; k < NST; k++) begin
            rem  = a_rem[k];
            work = a_work[k];
            for (int j = 0; j < STEP_N; j++) begin
                trial = {rem, work[RHC_QUO_W-1]};
                if (trial >= {1'b0, a_dvs[k]}) begin
                    rem  = REM_W'(trial - {1'b0, a_dvs[k]});
                    work = {work[RHC_QUO_W-2:0], 1'b1};
                end else begin
                    rem  = trial[REM_W-1:0];
                    work = {work[RHC_QUO_W-2:0], 1'b0};
                end
            end
            n_rem[k]  = rem;
            n_work[k] = work;
        end
    end

    // stage registers, payload only
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (i_en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_work[k] <= n_work[k];
                r_dvs[k]  <= a_dvs[k];
            end
        end
    end

    assign o_quo = r_work[NST-1];

endmodule

>>> sv/rgb_to_hsv_convert.sv
// RGB to HSV pixel converter.
// Input stream (s side): one pixel per transaction, tdata = red, green, blue
// from the low byte up. Output stream (m side): one HSV result per pixel, in
// order, tdata = hue (16 bits, fraction of a turn), saturation (16 bits,
// scaled by 65535), brightness (8 bits, largest channel) from the low bit up.
// The pipeline has 2 + 16/DIV_STEP stages; DIV_STEP defaults to two quotient
// bits per stage. The depth is set by the two restoring dividers (saturation
// and hue) that run side by side, one stage per DIV_STEP quotient bits, after
// a max/min stage and a sector/numerator stage.
// Throughput is one pixel per clock while results are taken. Every stage
// has its own valid bit and loads when it is empty or its successor moves,
// so bubbles close up and o_s_tready stays high while any stage is free,
// also while the result at the output waits for i_m_tready. A stall holds
// all data in place.
// Reset clears the valid bits only; the block is empty after reset.
module rgb_to_hsv_convert #(
    parameter int DIV_STEP = rhc_pkg::RHC_DIV_STEP
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [rhc_pkg::RHC_IN_W-1:0]  i_s_tdata,   // red, green, blue
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [rhc_pkg::RHC_OUT_W-1:0] o_m_tdata    // hue, saturation, brightness
);
    import rhc_pkg::*;

    localparam int NDIV = RHC_QUO_W / DIV_STEP;
    localparam int NS   = 2 + NDIV;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] c_en;

    logic [RHC_CHAN_W-1:0] c_red, c_green, c_blue;
    logic [RHC_CHAN_W-1:0] c_max, c_min;
    t_sector               c_sec;

    logic [RHC_CHAN_W-1:0] r1_red, r1_green, r1_blue, r1_max, r1_delta;
    t_sector               r1_sec;

    logic [RHC_SPAN_W-1:0]          c_span, c_num;
    logic [RHC_CHAN_W+RHC_QUO_W-1:0] c_sat_dvd;

    logic [RHC_SPAN_W-1:0] r2_num, r2_span;
    logic [RHC_CHAN_W-1:0] r2_sat_rem, r2_sat_dvs, r2_max;
    logic [RHC_QUO_W-1:0]  r2_sat_low;

    logic [RHC_CHAN_W-1:0] r_bri [NDIV];
    logic [RHC_QUO_W-1:0]  c_hue, c_sat;

    // stage load enables: a stage loads when empty or when its successor loads
    always_comb begin
        c_en[NS-1] = !r_vld[NS-1] || i_m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            c_en[k] = !r_vld[k] || c_en[k+1];
        end
    end

    assign o_s_tready = c_en[0];
    assign o_m_tvalid = r_vld[NS-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (c_en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (c_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: largest, smallest and hue sector
    assign c_red   = i_s_tdata[RHC_CHAN_W-1:0];
    assign c_green = i_s_tdata[2*RHC_CHAN_W-1:RHC_CHAN_W];
    assign c_blue  = i_s_tdata[3*RHC_CHAN_W-1:2*RHC_CHAN_W];

    always_comb begin
        if (c_red >= c_green && c_red >= c_blue) begin
            c_sec = SEC_RED;
            c_max = c_red;
        end else if (c_green >= c_blue) begin
            c_sec = SEC_GREEN;
            c_max = c_green;
        end else begin
            c_sec = SEC_BLUE;
            c_max = c_blue;
        end
        c_min = (c_red < c_green) ? c_red : c_green;
        if (c_blue < c_min) begin
            c_min = c_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en[0]) begin
            r1_red   <= c_red;
            r1_green <= c_green;
            r1_blue  <= c_blue;
            r1_max   <= c_max;
            r1_delta <= c_max - c_min;
            r1_sec   <= c_sec;
        end
    end

    // stage 2: hue numerator in [0, 6*delta), span and saturation dividend
    always_comb begin
        c_span = (RHC_SPAN_W'(r1_delta) << 2) + (RHC_SPAN_W'(r1_delta) << 1);
        unique case (r1_sec)
            SEC_RED: begin
                if (r1_green >= r1_blue) begin
                    c_num = RHC_SPAN_W'(r1_green) - RHC_SPAN_W'(r1_blue);
                end else begin
                    c_num = c_span + RHC_SPAN_W'(r1_green) - RHC_SPAN_W'(r1_blue);
                end
            end
            SEC_GREEN: begin
                c_num = (RHC_SPAN_W'(r1_delta) << 1) + RHC_SPAN_W'(r1_blue)
                        - RHC_SPAN_W'(r1_red);
            end
            SEC_BLUE: begin
                c_num = (RHC_SPAN_W'(r1_delta) << 2) + RHC_SPAN_W'(r1_red)
                        - RHC_SPAN_W'(r1_green);
            end
            default: begin
                c_num = '0;
            end
        endcase
        // 65535 * delta as (delta << 16) - delta
        c_sat_dvd = {r1_delta, {RHC_QUO_W{1'b0}}}
                    - (RHC_CHAN_W + RHC_QUO_W)'(r1_delta);
    end

    // grey pixel: numerator zero over one gives hue zero, and the
    // saturation dividend is already zero when max is zero
    always_ff @(posedge i_clk) begin
        if (c_en[1]) begin
            if (r1_delta == '0) begin
                r2_num  <= '0;
                r2_span <= RHC_SPAN_W'(1);
            end else begin
                r2_num  <= c_num;
                r2_span <= c_span;
            end
            r2_sat_rem <= c_sat_dvd[RHC_CHAN_W+RHC_QUO_W-1:RHC_QUO_W];
            r2_sat_low <= c_sat_dvd[RHC_QUO_W-1:0];
            r2_sat_dvs <= (r1_max == '0) ? RHC_CHAN_W'(1) : r1_max;
            r2_max     <= r1_max;
        end
    end

    // hue = floor(65536 * n / (6 * delta))
    rhc_div #(
        .REM_W  (RHC_SPAN_W),
        .STEP_N (DIV_STEP)
    ) u_hue_div (
        .i_clk  (i_clk),
        .i_en   (c_en[NS-1:2]),
        .i_rem  (r2_num),
        .i_work ('0),
        .i_dvs  (r2_span),
        .o_quo  (c_hue)
    );

    // saturation = floor(65535 * delta / max)
    rhc_div #(
        .REM_W  (RHC_CHAN_W),
        .STEP_N (DIV_STEP)
    ) u_sat_div (
        .i_clk  (i_clk),
        .i_en   (c_en[NS-1:2]),
        .i_rem  (r2_sat_rem),
        .i_work (r2_sat_low),
        .i_dvs  (r2_sat_dvs),
        .o_quo  (c_sat)
    );

    // brightness rides alongside the dividers
    always_ff @(posedge i_clk) begin
        if (c_en[2]) begin
            r_bri[0] <= r2_max;
        end
        for (int k = 1; k < NDIV; k++) begin
            if (c_en[k+2]) begin
                r_bri[k] <= r_bri[k-1];
            end
        end
    end

    assign o_m_tdata = {r_bri[NDIV-1], c_sat, c_hue};

    // an empty output stage means the whole pipeline can move
    a_ready_when_out_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready
    ) else $error("input not ready while output stage is empty");

    // zero saturation only for grey pixels, whose hue is zero
    a_grey_hue_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[RHC_HUE_W+RHC_SAT_W-1:RHC_HUE_W] == '0)
            |-> (o_m_tdata[RHC_HUE_W-1:0] == '0)
    ) else $error("grey pixel with nonzero hue");

    // black pixel has zero saturation
    a_black_sat_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[RHC_OUT_W-1:RHC_HUE_W+RHC_SAT_W] == '0)
            |-> (o_m_tdata[RHC_HUE_W+RHC_SAT_W-1:RHC_HUE_W] == '0)
    ) else $error("black pixel with nonzero saturation");

endmodule

>>> verif/tb_rgb_to_hsv_convert.sv
module tb_rgb_to_hsv_convert;

    localparam int CW = rhc_pkg::RHC_CHAN_W;
    localparam int HW = rhc_pkg::RHC_HUE_W;
    localparam int SW = rhc_pkg::RHC_SAT_W;

    // random part size and the long output hold-off
    localparam int N_RANDOM     = 1200;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 150;
    localparam int MAX_WAIT     = 12;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
    } t_rgb_pixel;

    typedef struct {
        t_rgb_pixel    pixel;
        logic [HW-1:0] hue;
        logic [SW-1:0] saturation;
        logic [CW-1:0] brightness;
    } t_hsv_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [rhc_pkg::RHC_IN_W-1:0]  i_s_tdata = '0;   // red, green, blue
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [rhc_pkg::RHC_OUT_W-1:0] o_m_tdata;        // hue, saturation, brightness

    t_rgb_pixel  pixels_to_send[$];
    t_hsv_result hsv_expected[$];

    logic hold_off = 1'b0;
    bit   src_burst = 1'b0;
    bit   sink_burst = 1'b0;
    int   src_gap;
    int   sink_wait;
    int   n_pixels_in;
    int   n_results;
    int   n_grey;
    int   n_input_stall;
    int   n_mismatch;

    rgb_to_hsv_convert i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // hexcone conversion with exact integer division
    function automatic t_hsv_result hsv_of_pixel(t_rgb_pixel p);
        t_hsv_result res;
        int r;
        int g;
        int b;
        int mx;
        int mn;
        int delta;
        int num;
        int h;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        delta = mx - mn;
        res.pixel = p;
        res.brightness = mx[CW-1:0];
        res.saturation = (mx != 0) ? SW'((65535 * delta) / mx) : '0;
        res.hue = '0;
        if (delta != 0) begin
            // red wins ties, then green
            if (mx == r) begin
                num = g - b;
                if (num < 0) num += 6 * delta;
            end else if (mx == g) begin
                num = 2 * delta + b - r;
            end else begin
                num = 4 * delta + r - g;
            end
            if (num < 0) num += 6 * delta;
            if (num >= 6 * delta) num -= 6 * delta;
            h = (num * 65536) / (6 * delta);
            res.hue = (h > 65535) ? 16'hffff : HW'(h);
        end
        return res;
    endfunction

    // mix of uniform, near-grey, tied-maximum and extreme pixels
    function automatic t_rgb_pixel random_pixel();
        t_rgb_pixel p;
        int base;
        int lo;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            p = t_rgb_pixel'((3 * CW)'($urandom));
        end else if (pick < 70) begin
            base = $urandom_range(1, 254);
            p.red   = CW'(base + $urandom_range(0, 2) - 1);
            p.green = CW'(base + $urandom_range(0, 2) - 1);
            p.blue  = CW'(base + $urandom_range(0, 2) - 1);
        end else if (pick < 88) begin
            base = $urandom_range(0, 255);
            lo = $urandom_range(0, base);
            case ($urandom_range(0, 2))
                0: p = '{red: CW'(base), green: CW'(base), blue: CW'(lo)};
                1: p = '{red: CW'(lo), green: CW'(base), blue: CW'(base)};
                default: p = '{red: CW'(base), green: CW'(lo), blue: CW'(base)};
            endcase
        end else begin
            p.red   = ($urandom_range(0, 1) ? 8'd254 : 8'd0) | CW'($urandom_range(0, 1));
            p.green = ($urandom_range(0, 1) ? 8'd254 : 8'd0) | CW'($urandom_range(0, 1));
            p.blue  = ($urandom_range(0, 1) ? 8'd254 : 8'd0) | CW'($urandom_range(0, 1));
        end
        return p;
    endfunction

    function automatic void queue_pixel(int r, int g, int b);
        t_rgb_pixel p;
        p = '{red: CW'(r), green: CW'(g), blue: CW'(b)};
        pixels_to_send = {pixels_to_send, p};
    endfunction

    // compare one output transaction with the oldest prediction
    task automatic check_result(input logic [rhc_pkg::RHC_OUT_W-1:0] data);
        t_hsv_result want;
        logic [HW-1:0] got_hue;
        logic [SW-1:0] got_sat;
        logic [CW-1:0] got_val;
        got_hue = data[HW-1:0];
        got_sat = data[HW+SW-1:HW];
        got_val = data[HW+SW+CW-1:HW+SW];
        if (hsv_expected.size() == 0) begin
            $error("result with no pixel pending: hue %0d sat %0d val %0d",
                   got_hue, got_sat, got_val);
            n_mismatch++;
        end else begin
            want = hsv_expected.pop_front();
            if (got_hue !== want.hue) begin
                $error("hue for rgb %0d,%0d,%0d: expected %0d, actual %0d",
                       want.pixel.red, want.pixel.green, want.pixel.blue,
                       want.hue, got_hue);
                n_mismatch++;
            end
            if (got_sat !== want.saturation) begin
                $error("saturation for rgb %0d,%0d,%0d: expected %0d, actual %0d",
                       want.pixel.red, want.pixel.green, want.pixel.blue,
                       want.saturation, got_sat);
                n_mismatch++;
            end
            if (got_val !== want.brightness) begin
                $error("brightness for rgb %0d,%0d,%0d: expected %0d, actual %0d",
                       want.pixel.red, want.pixel.green, want.pixel.blue,
                       want.brightness, got_val);
                n_mismatch++;
            end
        end
    endtask

    // pixel driver: one transaction per queued pixel, random gaps between
    always @(posedge i_clk) begin
        t_hsv_result pred;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_gap = $urandom_range(0, MAX_WAIT);
        end else begin
            if (i_s_tvalid && !o_s_tready) n_input_stall++;
            if (i_s_tvalid && o_s_tready) begin
                pred = hsv_of_pixel(pixels_to_send.pop_front());
                if (pred.saturation == '0) n_grey++;
                hsv_expected = {hsv_expected, pred};
                n_pixels_in++;
                src_gap = (src_burst || hold_off) ? 0 : $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
            end
            // a pixel on offer stays until taken
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pixels_to_send.size() != 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {pixels_to_send[0].blue, pixels_to_send[0].green,
                                   pixels_to_send[0].red};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                check_result(o_m_tdata);
                n_results++;
                sink_wait = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 49) == 0) sink_burst = !sink_burst;
            end
            if (hold_off) begin
                i_m_tready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // long output hold-off so the pipeline fills and stalls its input
    initial begin
        while (n_pixels_in < HOLD_AT) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // stimulus and end of run
    initial begin
        // black, white, greys
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(128, 128, 128);
        queue_pixel(1, 1, 1);
        // primaries and smallest non-zero channels
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 255);
        queue_pixel(1, 0, 0);
        queue_pixel(0, 1, 0);
        queue_pixel(0, 0, 1);
        // red sector wrapping just below a full turn
        queue_pixel(255, 0, 1);
        queue_pixel(255, 254, 255);
        // tied maxima
        queue_pixel(255, 255, 0);
        queue_pixel(0, 255, 255);
        queue_pixel(255, 0, 255);
        queue_pixel(1, 0, 1);
        // near ties and sector edges
        queue_pixel(255, 254, 0);
        queue_pixel(254, 255, 0);
        queue_pixel(0, 255, 254);
        queue_pixel(0, 254, 255);
        queue_pixel(255, 128, 0);
        queue_pixel(128, 255, 255);
        queue_pixel(254, 255, 254);
        for (int k = 0; k < N_RANDOM; k++) pixels_to_send = {pixels_to_send, random_pixel()};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pixels_to_send.size() != 0 || i_s_tvalid || hsv_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d pixels (%0d grey or black), %0d results checked",
                 n_pixels_in, n_grey, n_results);
        $display("input held back for %0d cycles by output back-pressure", n_input_stall);
        if (n_mismatch == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
